FILE: rtl/dtq_pkg.sv
// ---------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// Beat structs, opcodes, timer modes and cell control commands.
// ---------------------------------------------------------------------------
package dtq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam logic [7:0] TRIM_TICKS = 8'h01;
  localparam int MAX_TICKS_LOG2 = 8;          // 256 ticks
  localparam logic [7:0] FULL_COUNT = 8'hFF;
  localparam logic [10:0] TICK_RESET = 11'd4;

  localparam logic [0:0] CFG_ENABLE = 1'b0;
  localparam logic [0:0] CFG_TICK = 1'b1;

  localparam logic [2:0] OP_COMPARE = 3'd0;
  localparam logic [2:0] OP_OVERFLOW = 3'd1;
  localparam logic [2:0] OP_ONCE = 3'd2;
  localparam logic [2:0] OP_RATE = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_COMPARE = 2'd1;
  localparam logic [1:0] MODE_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [31:0] now_us;
    logic [31:0] delay_us;
    logic [31:0] initial_delay_us;
    logic [15:0] task_tag;
    logic [15:0] cancel_handle;
    logic from_handler;
  } in_beat_t;

  typedef struct packed {
    logic dispatched;
    logic [15:0] dispatched_tag;
    logic ok;
    logic [15:0] new_handle;
    logic [1:0] timer_mode;
    logic [7:0] compare_count;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] due;
    logic [31:0] queued;
    logic [31:0] period;
    logic [15:0] tag;
    logic rec;
    logic [15:0] handle;
  } entry_t;

  // command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,  // sorted insert of new_entry
    CMD_REMOVE   // remove cell at pos, shift upper cells down
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    entry_t new_entry;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CANCEL,
    ST_REQUEUE,
    ST_PROG,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/dtq_cell.sv
// ---------------------------------------------------------------------------
// dtq_cell: one slot of the sorted queue
// Holds one entry; on insert it keeps, takes the new entry or takes its lower
// neighbor; on remove it takes its upper neighbor.
// ---------------------------------------------------------------------------
module dtq_cell
  import dtq_pkg::*;
(
  input  logic clk,
  input  cell_ctl_t ctl,
  input  logic remove_here,   // this cell is at or above the removed slot
  input  logic lower_valid,   // lower neighbor occupied
  input  logic lower_le,      // lower neighbor due <= new due
  input  entry_t lower_entry,
  input  entry_t upper_entry,
  input  logic self_valid,
  output entry_t entry,
  output logic le_new
);

  assign le_new = self_valid && (entry.due <= ctl.new_entry.due);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_INSERT: begin
        // slot position = number of cells with due <= new
        if (!le_new) begin
          if (lower_valid && !lower_le) entry <= lower_entry;
          else entry <= ctl.new_entry;
        end
      end
      CMD_REMOVE: begin
        if (remove_here) entry <= upper_entry;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/dtq_divider.sv
// ---------------------------------------------------------------------------
// dtq_divider: radix-2 restoring divider for the compare count
// Gives diff / tick, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dtq_divider
  import dtq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [31:0] dividend,
  input  logic [10:0] divisor,
  output logic busy,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] dvd;
  logic [5:0] cnt;
  logic [32:0] trial;

  assign trial = {rem, dvd[31]} - {22'd0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd32;
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      if (!trial[32]) rem <= trial[31:0];
      else rem <= {rem[30:0], dvd[31]};
      dvd <= {dvd[30:0], !trial[32]};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  assign quotient = dvd;

endmodule

FILE: rtl/deadline_timer_queue_core.sv
// ---------------------------------------------------------------------------
// deadline_timer_queue_core: deadline-sorted timer task queue
// Row of queue cells kept in deadline order, a sequencer for the opcodes and
// a serial divider that turns the earliest deadline into a compare count.
// ---------------------------------------------------------------------------
//  channel | direction | handshake     | payload
//  in      | input     | in_valid/stall| in_beat_t
//  out     | output    | valid/stall   | out_beat_t
//  cfg     | input     | valid/ready   | cfg_index, cfg_data
//
//  One beat at a time. A schedule that needs the divider goes from accept
//  to the program state, the 32-step divider and the done state; a compare
//  event with a queued task first passes a requeue state. Insert or remove
//  is done in the cell row. Overflow or overdue deadlines skip the divider.
//  An unschedule walks the cells, one per cycle, until the handle is found or the occupied cells end.
//  Refused beats and handler schedules go straight to the done state.
//  Synchronous reset empties the queue at once; no clearing pass.
//  A waiting result holds in the output register while out_stall is high, and
//  the next input beat is taken the cycle after the result leaves.
// ---------------------------------------------------------------------------
module deadline_timer_queue_core
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_beat_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_beat_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;

  logic enable;
  logic [10:0] tick_us;
  logic [CW-1:0] count;
  logic [15:0] last_handle;
  logic [1:0] mode_now;
  logic [7:0] count_now;

  in_beat_t cur;
  out_beat_t res;
  out_beat_t res_acc;       // result fields known at accept
  logic [IW-1:0] scan;      // cancel walk pointer
  entry_t popped;

  entry_t cells [QUEUE_DEPTH];
  logic le [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vmask;
  cell_ctl_t ctl;
  logic [IW-1:0] rm_pos;

  logic full;
  assign full = (count == CW'(QUEUE_DEPTH));

  // ---- cell row ----------------------------------------------------------
  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      assign vmask[g] = (CW'(g) < count);
      dtq_cell u_cell (
        .clk(clk),
        .ctl(ctl),
        .remove_here(IW'(g) >= rm_pos),
        .lower_valid(g == 0 ? 1'b0 : vmask[(g == 0) ? 0 : g-1]),
        .lower_le(g == 0 ? 1'b1 : le[(g == 0) ? 0 : g-1]),
        .lower_entry(cells[(g == 0) ? 0 : g-1]),
        .upper_entry(cells[(g == QUEUE_DEPTH-1) ? g : g+1]),
        .self_valid(vmask[g]),
        .entry(cells[g]),
        .le_new(le[g])
      );
    end
  endgenerate

  // ---- timer program arithmetic on the head cell -------------------------
  logic [31:0] head_diff, head_diffq, diff_min;
  logic overdue, over_limit;
  logic [10:0] tick_eff;
  assign tick_eff = (tick_us == 11'd0) ? 11'd1 : tick_us;
  assign overdue = !(cells[0].due > cur.now_us);
  assign head_diff = cells[0].due - cur.now_us;
  assign head_diffq = cells[0].due - cells[0].queued;
  assign diff_min = (head_diffq < head_diff) ? head_diffq : head_diff;
  assign over_limit = {8'd0, diff_min} > ({29'd0, tick_eff} << MAX_TICKS_LOG2);

  logic div_start, div_busy;
  logic [31:0] quot;

  // head cell and cur are steady in ST_PROG, so the divider loads diff_min
  dtq_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(diff_min),
    .divisor(tick_eff), .busy(div_busy), .quotient(quot)
  );

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [15:0] handle_inc;
  assign handle_inc = (last_handle == 16'hFFFF) ? 16'd1 : last_handle + 16'd1;

  logic scan_hit;
  assign scan_hit = cells[scan].rec && (cells[scan].handle == cur.cancel_handle);

  assign in_stall = (state != ST_IDLE) || out_valid;
  // register writes only with nothing in flight and no beat offered
  assign cfg_ready = (state == ST_IDLE) && !out_valid && !in_valid;

  // ---- next state --------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && !in_stall) begin
        if (!enable) state_next = ST_DONE;
        else begin
          case (in_data.opcode)
            OP_COMPARE: state_next = (count != '0) ? ST_REQUEUE : ST_PROG;
            OP_OVERFLOW: state_next = ST_PROG;
            OP_ONCE: state_next = full ? ST_DONE : (in_data.from_handler ? ST_DONE : ST_PROG);
            OP_RATE: state_next = full ? ST_DONE : ST_PROG;
            OP_CANCEL: state_next = (in_data.cancel_handle == 16'd0 || count == '0) ?
                                    ST_DONE : ST_CANCEL;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_CANCEL: if (scan_hit || CW'(scan) + CW'(1) >= count) state_next = ST_DONE;
      ST_REQUEUE: state_next = ST_PROG;
      ST_PROG: state_next = (count == '0 || overdue || over_limit) ? ST_DONE : ST_DIV;
      ST_DIV: if (!div_busy) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- cell commands -----------------------------------------------------
  always_comb begin
    ctl.cmd = CMD_HOLD;
    ctl.new_entry = '0;
    rm_pos = '0;
    div_start = 1'b0;
    case (state)
      ST_IDLE: if (in_valid && !in_stall && enable) begin
        case (in_data.opcode)
          OP_COMPARE: if (count != '0) ctl.cmd = CMD_REMOVE;
          OP_ONCE: if (!full) begin
            ctl.cmd = CMD_INSERT;
            ctl.new_entry = '{due: sat_add(in_data.now_us, in_data.delay_us),
                              queued: in_data.now_us, period: in_data.delay_us,
                              tag: in_data.task_tag, rec: 1'b0, handle: 16'd0};
          end
          OP_RATE: if (!full) begin
            ctl.cmd = CMD_INSERT;
            ctl.new_entry = '{due: sat_add(in_data.now_us, in_data.initial_delay_us),
                              queued: in_data.now_us, period: in_data.delay_us,
                              tag: in_data.task_tag, rec: 1'b1, handle: handle_inc};
          end
          default: ;
        endcase
      end
      ST_CANCEL: if (scan_hit) begin
        ctl.cmd = CMD_REMOVE;
        rm_pos = scan;
      end
      ST_REQUEUE: if (popped.rec) begin
        ctl.cmd = CMD_INSERT;
        ctl.new_entry = '{due: sat_add(cur.now_us, popped.period), queued: cur.now_us,
                          period: popped.period, tag: popped.tag, rec: 1'b1,
                          handle: popped.handle};
      end
      ST_PROG: div_start = !(count == '0 || overdue || over_limit);
      default: ;
    endcase
  end

  // ---- result fields fixed at accept -------------------------------------
  always_comb begin
    res_acc = '0;
    if (enable) begin
      case (in_data.opcode)
        OP_COMPARE: begin
          res_acc.ok = 1'b1;
          if (count != '0) begin
            res_acc.dispatched = 1'b1;
            res_acc.dispatched_tag = cells[0].tag;
          end
        end
        OP_OVERFLOW: res_acc.ok = 1'b1;
        OP_ONCE: res_acc.ok = !full;
        OP_RATE: if (!full) begin
          res_acc.ok = 1'b1;
          res_acc.new_handle = handle_inc;
        end
        default: ;
      endcase
    end
  end

  // ---- registers ---------------------------------------------------------
  logic [32:0] cnt_full;
  assign cnt_full = {1'b0, quot} + 33'(TRIM_TICKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      enable <= 1'b0;
      tick_us <= TICK_RESET;
      count <= '0;
      last_handle <= '0;
      mode_now <= MODE_COMPARE;
      count_now <= FULL_COUNT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ENABLE) begin
          if (cfg_data[0] && !enable) begin
            mode_now <= MODE_COMPARE;
            count_now <= FULL_COUNT;
          end else if (!cfg_data[0] && enable) begin
            count <= '0;
            mode_now <= MODE_IDLE;
          end
          enable <= cfg_data[0];
        end else begin
          tick_us <= cfg_data;
        end
      end
      case (ctl.cmd)
        CMD_INSERT: count <= count + CW'(1);
        CMD_REMOVE: count <= count - CW'(1);
        default: ;
      endcase
      case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          cur <= in_data;
          popped <= cells[0];
          scan <= '0;
          res <= res_acc;
          if (enable && in_data.opcode == OP_RATE && !full) last_handle <= handle_inc;
        end
        ST_CANCEL: begin
          if (scan_hit) res.ok <= 1'b1;
          scan <= scan + IW'(1);
        end
        ST_PROG: begin
          if (count != '0) begin
            if (overdue) begin
              mode_now <= MODE_COMPARE;
              count_now <= TRIM_TICKS;
            end else if (over_limit) begin
              mode_now <= MODE_OVERFLOW;
            end
          end
        end
        ST_DIV: if (!div_busy) begin
          mode_now <= MODE_COMPARE;
          count_now <= (cnt_full > 33'(FULL_COUNT)) ? FULL_COUNT : cnt_full[7:0];
        end
        ST_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data = res;
    out_data.timer_mode = mode_now;
    out_data.compare_count = (mode_now == MODE_COMPARE) ? count_now : 8'd0;
  end

endmodule
